// ----- sv/bfa_pkg.sv -----
`default_nettype none
package bfa_pkg;

	localparam int FRAMES_DEF = 32768;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int WORD_BITS = 32;
	localparam int CFG_W = 16;

	typedef enum logic [2:0] {
		FUNC_CLEAR = 3'd0,
		FUNC_ALLOC = 3'd1,
		FUNC_FREE  = 3'd2,
		FUNC_MARK  = 3'd3,
		FUNC_COUNT = 3'd4
	} func_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] address;
		logic [19:0] first_frame;
		logic [20:0] stop_frame;
	} bfa_req_t;

	typedef struct packed {
		logic [31:0] frame_address;
		logic        failed;
		logic [15:0] used_count;
	} bfa_rsp_t;

	function automatic logic [5:0] popcount32(input logic [WORD_BITS-1:0] w);
		logic [3:0] part [4];
		logic [5:0] sum;
		for (int b = 0; b < 4; b++) begin
			part[b] = '0;
			for (int i = 0; i < 8; i++) begin
				part[b] = part[b] + 4'(w[b*8+i]);
			end
		end
		sum = 6'(part[0]) + 6'(part[1]) + 6'(part[2]) + 6'(part[3]);
		return sum;
	endfunction

	function automatic logic [4:0] onehot_index(input logic [WORD_BITS-1:0] oh);
		logic [4:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (oh[i]) begin
				idx = idx | 5'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

// ----- sv/bfa_ram.sv -----
`default_nettype none
module bfa_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  wire logic                           clk,
	input  wire logic                           re,
	input  wire logic [AW-1:0]                  raddr,
	output logic [bfa_pkg::WORD_BITS-1:0]       rdata,
	input  wire logic                           we,
	input  wire logic [AW-1:0]                  waddr,
	input  wire logic [bfa_pkg::WORD_BITS-1:0]  wdata
);
	import bfa_pkg::*;

	logic [WORD_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/bitmap_frame_allocator_top.sv -----
// A request that touches no word goes straight to the response; free reads one word, alloc
// walks from word 0 to the word holding the first free frame (every word within the bound
// when none is free), mark-range walks the words spanned, count walks ceil(bound/32) words,
// clear-all sweeps every word; one word per cycle through the RAM. A stalled response adds its wait.
// Requests: one at a time; the next is taken once the response is queued.
// Reset: asynchronous, then a sweep zeroes all WORDS RAM words (1024 by default), req_ready low.
`default_nettype none
module bitmap_frame_allocator_top #(
	parameter int FRAMES = bfa_pkg::FRAMES_DEF,
	parameter int PAGE_BYTES = bfa_pkg::PAGE_BYTES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	output logic                          req_ready,
	input  wire bfa_pkg::bfa_req_t        req,
	output logic                          rsp_valid,
	input  wire logic                     rsp_ready,
	output bfa_pkg::bfa_rsp_t             rsp,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [bfa_pkg::CFG_W-1:0] cfg_data
);
	import bfa_pkg::*;

	localparam int WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int FRW = 32 - PAGE_SHIFT;
	localparam logic [WA-1:0] LAST_WORD = WA'(WORDS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     total_q;
	logic [WA-1:0]        ptr_q;
	logic [WA-1:0]        stop_q;
	logic [WA-1:0]        startw_q;
	logic                 issue_q;
	logic                 clr_op_q;
	logic [2:0]           op_q;
	logic [15:0]          acc_q;
	logic [4:0]           bitlo_q;
	logic [4:0]           bithi_q;
	logic [BW-1:0]        bnd_q;
	bfa_rsp_t             res_q;
	bfa_rsp_t             rsp_q;
	logic                 rsp_valid_q;
	logic                 vld_s1;
	logic [WA-1:0]        addr_s1;

	logic                 ram_re;
	logic [WA-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	logic                 ram_we;
	logic [WA-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;

	logic [BW-1:0]        bound;
	logic [BW-1:0]        bound_m1;
	logic [FRW-1:0]       free_frame;
	logic                 free_ok;
	logic [20:0]          end_c;
	logic [20:0]          end_m1;
	logic                 range_ok;

	logic [BW-1:0]        bw_idx;
	logic [BW-1:0]        a_ext;
	logic [WORD_BITS-1:0] bmask;
	logic [WORD_BITS-1:0] avail;
	logic [WORD_BITS-1:0] lowest;
	logic                 found;
	logic                 last_word;
	logic [4:0]           lo_bit;
	logic [4:0]           hi_bit;
	logic [WORD_BITS-1:0] rmask;
	logic [5:0]           pop;
	logic [31:0]          alloc_addr;
	logic                 walk_data;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		bound = (BW'(total_q) > BW'(FRAMES)) ? BW'(FRAMES) : BW'(total_q);
		bound_m1 = bound - BW'(1);
		free_frame = req.address[31:PAGE_SHIFT];
		free_ok = (32'(free_frame) < 32'(FRAMES));
		end_c = (req.stop_frame > 21'(FRAMES)) ? 21'(FRAMES) : req.stop_frame;
		end_m1 = end_c - 21'd1;
		range_ok = (end_c > 21'(req.first_frame));
	end

	always_comb begin
		bw_idx = bnd_q >> 5;
		a_ext = BW'(addr_s1);
		if (a_ext < bw_idx) begin
			bmask = '1;
		end else if (a_ext == bw_idx) begin
			bmask = ~(32'hFFFF_FFFF << bnd_q[4:0]);
		end else begin
			bmask = '0;
		end
		avail = ~ram_rdata & bmask;
		lowest = avail & (~avail + 32'd1);
		found = |avail;
		last_word = (addr_s1 == stop_q);
		lo_bit = (addr_s1 == startw_q) ? bitlo_q : 5'd0;
		hi_bit = last_word ? bithi_q : 5'd31;
		rmask = (32'hFFFF_FFFF << lo_bit) & (32'hFFFF_FFFF >> (5'd31 - hi_bit));
		pop = popcount32(ram_rdata & bmask);
		alloc_addr = 32'({addr_s1, onehot_index(lowest)}) << PAGE_SHIFT;
		walk_data = (state_q == ST_WALK) && vld_s1;
	end

	always_comb begin
		ram_re = (state_q == ST_WALK) && issue_q;
		ram_raddr = ptr_q;
		ram_we = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = ram_rdata;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = ptr_q;
			ram_wdata = '0;
		end else if (walk_data) begin
			unique case (op_q)
				FUNC_ALLOC: begin
					ram_we = found;
					ram_wdata = ram_rdata | lowest;
				end
				FUNC_FREE: begin
					ram_we = 1'b1;
					ram_wdata = ram_rdata & ~(32'd1 << bitlo_q);
				end
				FUNC_MARK: begin
					ram_we = 1'b1;
					ram_wdata = ram_rdata | rmask;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	bfa_ram #(
		.DEPTH(WORDS),
		.AW(WA)
	) u_ram (
		.clk(clk),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			total_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q <= '0;
			stop_q <= '0;
			startw_q <= '0;
			issue_q <= 1'b0;
			clr_op_q <= 1'b0;
			op_q <= '0;
			acc_q <= '0;
			bitlo_q <= '0;
			bithi_q <= '0;
			bnd_q <= '0;
			res_q <= '0;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ram_re;
			if (rsp_valid_q && rsp_ready && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + WA'(1);
					if (ptr_q == LAST_WORD) begin
						state_q <= clr_op_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						op_q <= req.func;
						acc_q <= '0;
						issue_q <= 1'b1;
						bnd_q <= bound;
						unique case (req.func)
							FUNC_CLEAR: begin
								res_q <= '0;
								ptr_q <= '0;
								clr_op_q <= 1'b1;
								state_q <= ST_CLEAR;
							end
							FUNC_ALLOC: begin
								res_q <= {32'd0, (bound == '0), 16'd0};
								ptr_q <= '0;
								stop_q <= WA'(bound_m1 >> 5);
								state_q <= (bound == '0) ? ST_FIN : ST_WALK;
							end
							FUNC_FREE: begin
								res_q <= '0;
								ptr_q <= WA'(free_frame >> 5);
								stop_q <= WA'(free_frame >> 5);
								bitlo_q <= free_frame[4:0];
								state_q <= free_ok ? ST_WALK : ST_FIN;
							end
							FUNC_MARK: begin
								res_q <= '0;
								ptr_q <= WA'(req.first_frame >> 5);
								startw_q <= WA'(req.first_frame >> 5);
								stop_q <= WA'(end_m1 >> 5);
								bitlo_q <= req.first_frame[4:0];
								bithi_q <= end_m1[4:0];
								state_q <= range_ok ? ST_WALK : ST_FIN;
							end
							FUNC_COUNT: begin
								res_q <= '0;
								ptr_q <= '0;
								stop_q <= WA'(bound_m1 >> 5);
								state_q <= (bound != '0) ? ST_WALK : ST_FIN;
							end
							default: begin
								res_q <= '0;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (ram_re) begin
						ptr_q <= ptr_q + WA'(1);
						if (ptr_q == stop_q) begin
							issue_q <= 1'b0;
						end
					end
					if (vld_s1) begin
						unique case (op_q)
							FUNC_ALLOC: begin
								if (found) begin
									res_q.frame_address <= alloc_addr;
									state_q <= ST_FIN;
								end else if (last_word) begin
									res_q.failed <= 1'b1;
									state_q <= ST_FIN;
								end
							end
							FUNC_COUNT: begin
								acc_q <= acc_q + 16'(pop);
								if (last_word) begin
									res_q.used_count <= acc_q + 16'(pop);
									state_q <= ST_FIN;
								end
							end
							default: begin
								if (last_word) begin
									state_q <= ST_FIN;
								end
							end
						endcase
					end
				end
				ST_FIN: begin
					clr_op_q <= 1'b0;
					issue_q <= 1'b0;
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q <= res_q;
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_rw_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_re && ram_we) |-> (ram_raddr != ram_waddr))
		else $error("bitmap RAM read and write hit the same word");

	a_count_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && op_q == FUNC_COUNT) |-> !ram_we)
		else $error("count walk modified the bitmap");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.failed) |-> (rsp.frame_address == '0 && rsp.used_count == '0))
		else $error("failed response carries nonzero fields");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && rsp_valid_q && !rsp_ready) |=>
		(state_q == ST_FIN && $stable(rsp_q)))
		else $error("response overwritten before transaction completed");
`endif

endmodule
`default_nettype wire

// ----- sim/bitmap_frame_allocator_top_tb.sv -----
`default_nettype none
import bfa_pkg::*;

class frame_ledger;
	bit [WORD_BITS-1:0] used_words [FRAMES_DEF / WORD_BITS];
	bit [CFG_W-1:0] total_frames;
	bfa_rsp_t pending_rsps [$];
	int errors;

	function new();
		foreach (used_words[i]) used_words[i] = '0;
		total_frames = '0;
		errors = 0;
	endfunction

	function void set_total(bit [CFG_W-1:0] v);
		total_frames = v;
	endfunction

	function void note_request(bfa_req_t r);
		bfa_rsp_t want;
		int unsigned bound;
		int unsigned f;
		int unsigned stop;
		int unsigned frame;
		int unsigned cnt;
		want = '0;
		cnt = 0;
		bound = (total_frames > FRAMES_DEF) ? FRAMES_DEF : total_frames;
		case (r.func)
			FUNC_CLEAR: begin
				foreach (used_words[i]) used_words[i] = '0;
			end
			FUNC_ALLOC: begin
				want.failed = 1'b1;
				for (f = 0; f < bound; f++) begin
					if (!used_words[f / WORD_BITS][f % WORD_BITS]) begin
						used_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
						want.frame_address = 32'(64'(f) * PAGE_BYTES_DEF);
						want.failed = 1'b0;
						break;
					end
				end
			end
			FUNC_FREE: begin
				frame = r.address / PAGE_BYTES_DEF;
				if (frame < FRAMES_DEF)
					used_words[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
			end
			FUNC_MARK: begin
				stop = r.stop_frame;
				if (stop > FRAMES_DEF)
					stop = FRAMES_DEF;
				for (f = r.first_frame; f < stop; f++)
					used_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
			end
			FUNC_COUNT: begin
				for (f = 0; f < bound; f++)
					if (used_words[f / WORD_BITS][f % WORD_BITS])
						cnt++;
				want.used_count = 16'(cnt);
			end
			default: ;
		endcase
		pending_rsps.push_back(want);
	endfunction

	function void check_response(bfa_rsp_t got);
		bfa_rsp_t want;
		if (pending_rsps.size() == 0) begin
			$error("response with nothing pending: frame_address %h failed %0d used_count %0d",
				got.frame_address, got.failed, got.used_count);
			errors++;
			return;
		end
		want = pending_rsps.pop_front();
		if (got.frame_address !== want.frame_address) begin
			$error("frame_address mismatch: expected %h, actual %h",
				want.frame_address, got.frame_address);
			errors++;
		end
		if (got.failed !== want.failed) begin
			$error("failed mismatch: expected %0d, actual %0d", want.failed, got.failed);
			errors++;
		end
		if (got.used_count !== want.used_count) begin
			$error("used_count mismatch: expected %0d, actual %0d",
				want.used_count, got.used_count);
			errors++;
		end
	endfunction
endclass

module bitmap_frame_allocator_top_tb;

	localparam int unsigned CYCLE_LIMIT = 12000000;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned TAIL_CYCLES = 1100;
	localparam int unsigned END_LIMIT = 1048576;
	localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] FUNC_UNUSED_LAST = 3'd7;
	localparam int NUM_PHASES = 10;
	localparam int unsigned PHASE_TOTAL [NUM_PHASES] =
		'{0, 1, 33, 64, 200, 1000, 65535, 32768, 32767, 97};
	localparam int unsigned PHASE_ITEMS [NUM_PHASES] =
		'{40, 100, 250, 300, 300, 250, 60, 60, 40, 300};
	localparam int PRESSURE_PHASE = 4;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	bfa_req_t req;
	logic rsp_valid;
	logic rsp_ready;
	bfa_rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	logic rsp_hold;
	int unsigned send_idle_pct;
	int unsigned rsp_stall_pct;
	int unsigned cycle_count;

	frame_ledger sb;

	bitmap_frame_allocator_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic bfa_req_t mk(logic [2:0] fn, logic [31:0] a, logic [19:0] ff,
			logic [20:0] ef);
		bfa_req_t r;
		r.func = fn;
		r.address = a;
		r.first_frame = ff;
		r.stop_frame = ef;
		return r;
	endfunction

	function automatic int unsigned pick_frame(int unsigned bound);
		int unsigned sel;
		int unsigned lim;
		sel = $urandom_range(1, 100);
		lim = (bound == 0) ? 16 : ((bound > 4096) ? 4096 : bound + 8);
		if (sel <= 80)
			return $urandom_range(0, lim - 1);
		else if (sel <= 92)
			return $urandom_range(0, FRAMES_DEF - 1);
		return $urandom_range(0, 20'hFFFFF);
	endfunction

	function automatic bfa_req_t rand_req(int unsigned bound);
		bfa_req_t r;
		int unsigned pick;
		int unsigned sel;
		int unsigned first;
		int unsigned stop;
		int unsigned sub;
		r.func = FUNC_CLEAR;
		r.address = $urandom;
		r.first_frame = 20'($urandom);
		r.stop_frame = 21'($urandom_range(0, END_LIMIT));
		pick = $urandom_range(1, 100);
		if (pick <= 3) begin
			r.func = FUNC_CLEAR;
		end else if (pick <= 40) begin
			r.func = FUNC_ALLOC;
		end else if (pick <= 65) begin
			r.func = FUNC_FREE;
			if ($urandom_range(1, 100) <= 85)
				r.address = 32'(pick_frame(bound)) * 32'(PAGE_BYTES_DEF)
					+ 32'($urandom_range(0, PAGE_BYTES_DEF - 1));
		end else if (pick <= 82) begin
			r.func = FUNC_MARK;
			first = pick_frame(bound);
			sel = $urandom_range(1, 100);
			if (sel <= 55) begin
				stop = first + $urandom_range(0, 40);
			end else if (sel <= 70) begin
				stop = first + $urandom_range(0, 300);
			end else if (sel <= 85) begin
				sub = $urandom_range(0, 20);
				stop = (first > sub) ? first - sub : 0;
			end else if (sel <= 95) begin
				stop = $urandom_range(0, END_LIMIT);
			end else begin
				stop = END_LIMIT;
			end
			if (stop > END_LIMIT)
				stop = END_LIMIT;
			r.first_frame = 20'(first);
			r.stop_frame = 21'(stop);
		end else if (pick <= 96) begin
			r.func = FUNC_COUNT;
		end else begin
			r.func = 3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
		end
		return r;
	endfunction

	task automatic send_req(input bfa_req_t r);
		while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending_rsps.size() != 0) @(posedge clk);
	endtask

	task automatic write_total(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_total(v);
	endtask

	task automatic set_idle_mode(input int mode);
		case (mode)
			0: begin send_idle_pct = 0; rsp_stall_pct = 0; end
			1: begin send_idle_pct = 84; rsp_stall_pct = 0; end
			2: begin send_idle_pct = 0; rsp_stall_pct = 84; end
			default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
		endcase
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
			rsp_ready <= !rsp_hold && ($urandom_range(1, 100) > rsp_stall_pct);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b1;
		rsp_hold = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		set_idle_mode(0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// zero bound straight out of reset
		send_req(mk(FUNC_COUNT, '0, '0, '0));
		send_req(mk(FUNC_ALLOC, '0, '0, '0));
		drain();
		write_total(16'd64);
		send_req(mk(FUNC_ALLOC, '0, '0, '0));
		send_req(mk(FUNC_ALLOC, '0, '0, '0));
		send_req(mk(FUNC_MARK, '0, 20'd10, 21'd20));
		send_req(mk(FUNC_COUNT, '0, '0, '0));
		send_req(mk(FUNC_FREE, 32'h0000_1ABC, '0, '0));
		send_req(mk(FUNC_ALLOC, '0, '0, '0));
		send_req(mk(FUNC_MARK, '0, 20'd30, 21'd20));
		send_req(mk(FUNC_MARK, '0, 20'd5, 21'd5));
		send_req(mk(FUNC_FREE, 32'hFFFF_FFFF, '0, '0));
		send_req(mk(FUNC_FREE, 32'h0800_0000, '0, '0));
		send_req(mk(FUNC_MARK, '0, 20'd32760, 21'h100000));
		send_req(mk(FUNC_MARK, '0, 20'hFFFFF, 21'h100000));
		send_req(mk(FUNC_COUNT, '0, '0, '0));
		for (int c = FUNC_UNUSED_FIRST; c <= FUNC_UNUSED_LAST; c++)
			send_req(mk(3'(c), 32'hFFFF_FFFF, 20'hFFFFF, 21'h100000));
		send_req(mk(FUNC_MARK, '0, 20'd0, 21'd64));
		send_req(mk(FUNC_ALLOC, '0, '0, '0));
		send_req(mk(FUNC_COUNT, '0, '0, '0));
		drain();
		write_total(16'hFFFF);
		send_req(mk(FUNC_COUNT, '0, '0, '0));
		send_req(mk(FUNC_ALLOC, '0, '0, '0));
		send_req(mk(FUNC_CLEAR, '0, '0, '0));
		send_req(mk(FUNC_COUNT, '0, '0, '0));

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_total(CFG_W'(PHASE_TOTAL[p]));
			set_idle_mode(p % 4);
			if (p == PRESSURE_PHASE) begin
				fork
					begin
						rsp_hold <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						rsp_hold <= 1'b0;
					end
				join_none
			end
			for (int n = 0; n < PHASE_ITEMS[p]; n++)
				send_req(rand_req(sb.total_frames));
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_rsps.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
sv/bfa_pkg.sv
sv/bfa_ram.sv
sv/bitmap_frame_allocator_top.sv
sim/bitmap_frame_allocator_top_tb.sv
